FILE: src/conv3_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register codes of the 3x3 convolution filter
package conv3_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned CFG_W  = 12;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned THR_W  = 11;
  localparam int unsigned CNT_W  = 23;
  localparam int unsigned TOT_W  = 24;
  localparam int unsigned ROW_W  = 13;
  localparam int unsigned IDX_CW = 2;

  // register indexes
  localparam logic [IDX_CW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_CW-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_CW-1:0] REG_MODE   = 2'd2;
  localparam logic [IDX_CW-1:0] REG_THRESH = 2'd3;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_BOX    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GAUSS  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SHARP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SOBEL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VDIFF  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_EMBOSS = 3'd5;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;
  localparam logic [TOT_W-1:0] RESET_TOTAL  = 24'd307200;

  // floor(s/9) = (s*7282)>>16 for s < 4096, floor(s/3) = (s*683)>>11 for s < 2048
  localparam logic [12:0] RECIP9 = 13'd7282;
  localparam logic [9:0]  RECIP3 = 10'd683;

  typedef struct packed {
    logic [8:0][23:0] win;
    logic [7:0]       alpha;
    logic             border;
    logic             eof;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [THR_W-1:0]  thresh;
  } filt_cfg_t;

endpackage

FILE: src/conv3_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module conv3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/conv3_fifo.sv
`timescale 1ns / 1ps
// short queue of window snapshots between front and back
module conv3_fifo #(
  parameter int unsigned DEPTH = conv3_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  conv3_pkg::entry_t  entry_i,
  input  logic               pop_i,
  output conv3_pkg::entry_t  entry_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  conv3_pkg::entry_t slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/conv3_front.sv
`timescale 1ns / 1ps
// front end: takes pixels, keeps line stores, window and counters, queues windows
module conv3_front #(
  parameter int unsigned MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            is_flush_i,
  input  logic [7:0]                      red_in_i,
  input  logic [7:0]                      green_in_i,
  input  logic [7:0]                      blue_in_i,
  input  logic [7:0]                      alpha_in_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [conv3_pkg::IDX_CW-1:0]    cfg_index_i,
  input  logic [conv3_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output conv3_pkg::entry_t               q_entry_o,
  output conv3_pkg::filt_cfg_t            filt_cfg_o
);

  localparam int unsigned IDX_W = $clog2(MAX_WIDTH);
  localparam int unsigned CMP_W = ((IDX_W > conv3_pkg::CFG_W) ? IDX_W : conv3_pkg::CFG_W) + 1;
  localparam int unsigned CNT_W = conv3_pkg::CNT_W;
  localparam int unsigned TOT_W = conv3_pkg::TOT_W;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_READ = 5'b00010,
    F_UPD  = 5'b00100,
    F_DIV  = 5'b01000,
    F_MUL  = 5'b10000
  } fstate_e;

  fstate_e state_q;

  logic [conv3_pkg::CFG_W-1:0]  w_q, h_q;
  logic [conv3_pkg::MODE_W-1:0] mode_q;
  logic [conv3_pkg::THR_W-1:0]  thr_q;
  logic [TOT_W-1:0]             total_q;
  logic [IDX_W-1:0]             col_q, x_q;
  logic [conv3_pkg::ROW_W-1:0]  row_q;
  logic [CNT_W-1:0]             cnt_q, y_q;
  logic [8:0][23:0]             win_q, win_d;
  logic [31:0]                  px_q, up_c_q, mid_c_q;

  // restoring divider for count / width
  logic [CNT_W-1:0]               dvd_q, quo_q, quo_d;
  logic [conv3_pkg::CFG_W-1:0]    rem_q, rem_d;
  logic [conv3_pkg::CFG_W:0]      rem_sh;
  logic [4:0]                     div_cnt_q;
  logic                           div_bit;

  logic [31:0] up_rdata, mid_rdata;
  logic [IDX_W-1:0] up_raddr;
  logic ram_we;

  logic accept, emit, col_wrap, x_last, border, eof;
  logic [CMP_W-1:0] w_ext, data_ext;
  logic [conv3_pkg::CFG_W-1:0] w_eff;

  assign cfg_ready_o = (state_q == F_IDLE);
  assign in_stall_o  = !((state_q == F_IDLE) && !q_full_i && !cfg_valid_i);
  assign accept      = in_valid_i && !in_stall_o;

  assign w_ext    = CMP_W'(w_q);
  assign data_ext = CMP_W'(cfg_data_i);

  always_comb begin
    if (cfg_data_i == '0) begin
      w_eff = 12'd1;
    end else if (data_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = conv3_pkg::CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_data_i;
    end
  end

  assign emit     = (row_q >= 13'd2) || ((row_q == 13'd1) && (col_q != '0));
  assign col_wrap = (CMP_W'(col_q) + 1'b1) >= w_ext;
  assign x_last   = (CMP_W'(x_q) + 1'b1) >= w_ext;
  assign border   = (x_q == '0) || x_last || (y_q == '0)
                    || ((TOT_W'(y_q) + 1'b1) >= TOT_W'(h_q));
  assign eof      = (TOT_W'(cnt_q) + 1'b1) >= total_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[3*r]   = win_q[3*r+1];
      win_d[3*r+1] = win_q[3*r+2];
    end
    win_d[2] = up_c_q[23:0];
    win_d[5] = mid_c_q[23:0];
    win_d[8] = px_q[23:0];
  end

  assign rem_sh  = {rem_q, dvd_q[CNT_W-1]};
  assign div_bit = rem_sh >= (conv3_pkg::CFG_W + 1)'(w_q);
  assign rem_d   = div_bit ? conv3_pkg::CFG_W'(rem_sh - (conv3_pkg::CFG_W + 1)'(w_q))
                           : conv3_pkg::CFG_W'(rem_sh);
  assign quo_d   = {quo_q[CNT_W-2:0], div_bit};

  assign up_raddr = (state_q == F_READ) ? x_q : col_q;
  assign ram_we   = (state_q == F_UPD);

  conv3_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (mid_c_q),
    .raddr_i (up_raddr),
    .rdata_o (up_rdata)
  );

  conv3_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (px_q),
    .raddr_i (col_q),
    .rdata_o (mid_rdata)
  );

  assign q_push_o         = (state_q == F_UPD) && emit;
  assign q_entry_o.win    = win_d;
  assign q_entry_o.alpha  = up_rdata[31:24];
  assign q_entry_o.border = border;
  assign q_entry_o.eof    = eof;
  assign filt_cfg_o.mode   = mode_q;
  assign filt_cfg_o.thresh = thr_q;

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= is_flush_i ? '0 : {alpha_in_i, blue_in_i, green_in_i, red_in_i};
    end
    if (state_q == F_READ) begin
      up_c_q  <= up_rdata;
      mid_c_q <= mid_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      w_q       <= conv3_pkg::RESET_WIDTH;
      h_q       <= conv3_pkg::RESET_HEIGHT;
      mode_q    <= conv3_pkg::MODE_BOX;
      thr_q     <= '0;
      total_q   <= conv3_pkg::RESET_TOTAL;
      col_q     <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
      x_q       <= '0;
      y_q       <= '0;
      win_q     <= '0;
      dvd_q     <= '0;
      quo_q     <= '0;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (cfg_valid_i) begin
            case (cfg_index_i)
              conv3_pkg::REG_WIDTH: begin
                w_q       <= w_eff;
                dvd_q     <= cnt_q;
                quo_q     <= '0;
                rem_q     <= '0;
                div_cnt_q <= '0;
                state_q   <= F_DIV;
              end
              conv3_pkg::REG_HEIGHT: begin
                h_q     <= (cfg_data_i == '0) ? 12'd1 : cfg_data_i;
                state_q <= F_MUL;
              end
              conv3_pkg::REG_MODE:   mode_q <= cfg_data_i[conv3_pkg::MODE_W-1:0];
              conv3_pkg::REG_THRESH: thr_q  <= cfg_data_i[conv3_pkg::THR_W-1:0];
              default: ;
            endcase
          end else if (accept) begin
            state_q <= F_READ;
          end
        end
        F_READ: begin
          state_q <= F_UPD;
        end
        F_UPD: begin
          win_q <= win_d;
          if (emit && eof) begin
            col_q <= '0;
            row_q <= '0;
            cnt_q <= '0;
            x_q   <= '0;
            y_q   <= '0;
          end else begin
            if (col_wrap) begin
              col_q <= '0;
              row_q <= row_q + 1'b1;
            end else begin
              col_q <= col_q + 1'b1;
            end
            if (emit) begin
              cnt_q <= cnt_q + 1'b1;
              if (x_last) begin
                x_q <= '0;
                y_q <= y_q + 1'b1;
              end else begin
                x_q <= x_q + 1'b1;
              end
            end
          end
          state_q <= F_IDLE;
        end
        F_DIV: begin
          dvd_q     <= {dvd_q[CNT_W-2:0], 1'b0};
          quo_q     <= quo_d;
          rem_q     <= rem_d;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 5'(CNT_W - 1)) begin
            x_q     <= IDX_W'(rem_d);
            y_q     <= quo_d;
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          total_q <= TOT_W'(w_q) * TOT_W'(h_q);
          state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: src/conv3_back.sv
`timescale 1ns / 1ps
// back end: filters one queued window per pass and holds the result register
module conv3_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  conv3_pkg::entry_t     q_entry_i,
  output logic                  q_pop_o,
  input  conv3_pkg::filt_cfg_t  filt_cfg_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic [7:0]            alpha_out_o,
  output logic                  end_of_frame_o
);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_SUMS = 7'b0000010,
    B_GRAY = 7'b0000100,
    B_HV   = 7'b0001000,
    B_SQ   = 7'b0010000,
    B_ROOT = 7'b0100000,
    B_DONE = 7'b1000000
  } bstate_e;

  bstate_e state_q;

  logic [8:0][23:0]   win_q;
  logic [7:0]         alpha_q;
  logic               border_q, eof_q;
  logic signed [12:0] acc_q [3];
  logic signed [12:0] acc_d [3];
  logic [9:0]         gsum_q [9];
  logic [9:0]         gsum_d [9];
  logic [7:0]         gray_q [9];
  logic [7:0]         gray_d [9];
  logic [7:0]         res_q [3];
  logic [7:0]         res_d [3];
  logic [7:0]         root_res;
  logic signed [11:0] h_q, v_q, h_d, v_d;
  logic signed [22:0] h_sq, v_sq, n_sum;
  logic [20:0]        n_q;
  logic [11:0]        root_q, bit_q, trial, root_d;
  logic [23:0]        trial_sq;
  logic [7:0]         gray_c;
  logic [19:0]        gray_c_prod;
  logic               out_free;

  logic [7:0] out_r_q, out_g_q, out_b_q, out_a_q;
  logic       out_eof_q, out_valid_q;

  function automatic logic [7:0] clamp8(input logic signed [12:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 13'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // per channel kernel sums and per pixel channel sums for gray
  always_comb begin
    logic signed [12:0] p [9];
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 9; i++) begin
        p[i] = $signed({5'b0, win_q[i][8*k +: 8]});
      end
      case (filt_cfg_i.mode)
        conv3_pkg::MODE_BOX:
          acc_d[k] = p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7] + p[8];
        conv3_pkg::MODE_GAUSS:
          acc_d[k] = p[0] + (p[1] <<< 1) + p[2] + (p[3] <<< 1) + (p[4] <<< 2)
                     + (p[5] <<< 1) + p[6] + (p[7] <<< 1) + p[8];
        conv3_pkg::MODE_SHARP:
          acc_d[k] = (p[4] <<< 2) + p[4] - p[1] - p[3] - p[5] - p[7];
        default:
          acc_d[k] = p[1] - p[7];
      endcase
    end
    for (int i = 0; i < 9; i++) begin
      gsum_d[i] = 10'(win_q[i][7:0]) + 10'(win_q[i][15:8]) + 10'(win_q[i][23:16]);
    end
  end

  // final channel values and gray values
  always_comb begin
    logic [25:0] prod9;
    logic [19:0] gprod;
    for (int i = 0; i < 9; i++) begin
      gprod     = 20'(gsum_q[i]) * 20'(conv3_pkg::RECIP3);
      gray_d[i] = gprod[18:11];
    end
    gray_c_prod = 20'(gsum_q[4]) * 20'(conv3_pkg::RECIP3);
    gray_c      = gray_c_prod[18:11];
    for (int k = 0; k < 3; k++) begin
      prod9 = 26'(unsigned'(acc_q[k])) * 26'(conv3_pkg::RECIP9);
      if (filt_cfg_i.mode == conv3_pkg::MODE_SOBEL) begin
        res_d[k] = gray_c;
      end else if (border_q) begin
        res_d[k] = win_q[4][8*k +: 8];
      end else begin
        case (filt_cfg_i.mode)
          conv3_pkg::MODE_BOX:    res_d[k] = prod9[23:16];
          conv3_pkg::MODE_GAUSS:  res_d[k] = acc_q[k][11:4];
          conv3_pkg::MODE_SHARP:  res_d[k] = clamp8(acc_q[k]);
          conv3_pkg::MODE_VDIFF:  res_d[k] = acc_q[k][7:0];
          conv3_pkg::MODE_EMBOSS: res_d[k] = clamp8(acc_q[k] + 13'sd128);
          default:                res_d[k] = win_q[4][8*k +: 8];
        endcase
      end
    end
  end

  // sobel gradients
  always_comb begin
    logic signed [11:0] g [9];
    for (int i = 0; i < 9; i++) begin
      g[i] = $signed({4'b0, gray_q[i]});
    end
    h_d = (g[0] - g[2]) + ((g[3] - g[5]) <<< 1) + (g[6] - g[8]);
    v_d = (g[6] - g[0]) + ((g[7] - g[1]) <<< 1) + (g[8] - g[2]);
  end

  // squared magnitude at full width
  assign h_sq  = h_q * h_q;
  assign v_sq  = v_q * v_q;
  assign n_sum = h_sq + v_sq;

  // one root bit per cycle
  assign trial    = root_q | bit_q;
  assign trial_sq = 24'(trial) * 24'(trial);
  assign root_d   = (trial_sq <= 24'(n_q)) ? trial : root_q;

  always_comb begin
    if (root_d < 12'(filt_cfg_i.thresh)) begin
      root_res = 8'd0;
    end else if (root_d > 12'd255) begin
      root_res = 8'd255;
    end else begin
      root_res = root_d[7:0];
    end
  end

  assign q_pop_o  = (state_q == B_IDLE) && q_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign red_out_o      = out_r_q;
  assign green_out_o    = out_g_q;
  assign blue_out_o     = out_b_q;
  assign alpha_out_o    = out_a_q;
  assign end_of_frame_o = out_eof_q;

  // datapath
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      win_q    <= q_entry_i.win;
      alpha_q  <= q_entry_i.alpha;
      border_q <= q_entry_i.border;
      eof_q    <= q_entry_i.eof;
    end
    if (state_q == B_SUMS) begin
      acc_q  <= acc_d;
      gsum_q <= gsum_d;
    end
    if (state_q == B_GRAY) begin
      gray_q <= gray_d;
      res_q  <= res_d;
    end
    if (state_q == B_HV) begin
      h_q <= h_d;
      v_q <= v_d;
    end
    if (state_q == B_SQ) begin
      n_q    <= n_sum[20:0];
      root_q <= '0;
      bit_q  <= 12'h800;
    end
    if (state_q == B_ROOT) begin
      root_q <= root_d;
      bit_q  <= bit_q >> 1;
      if (bit_q[0]) begin
        res_q[0] <= root_res;
        res_q[1] <= root_res;
        res_q[2] <= root_res;
      end
    end
    if ((state_q == B_DONE) && out_free) begin
      out_r_q   <= res_q[0];
      out_g_q   <= res_q[1];
      out_b_q   <= res_q[2];
      out_a_q   <= alpha_q;
      out_eof_q <= eof_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ((state_q == B_DONE) && out_free) || (out_valid_q && out_stall_i);
      case (state_q)
        B_IDLE: if (q_valid_i) state_q <= B_SUMS;
        B_SUMS: state_q <= B_GRAY;
        B_GRAY: begin
          if ((filt_cfg_i.mode == conv3_pkg::MODE_SOBEL) && !border_q) begin
            state_q <= B_HV;
          end else begin
            state_q <= B_DONE;
          end
        end
        B_HV:   state_q <= B_SQ;
        B_SQ:   state_q <= B_ROOT;
        B_ROOT: if (bit_q[0]) state_q <= B_DONE;
        B_DONE: begin
          if (out_free) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: src/image_3x3_convolution_filter_top.sv
`timescale 1ns / 1ps
// top level of the 3x3 image convolution filter
// the front takes a pixel, reads the line stores, reads alpha and writes back, with input stalled
// per result the back end passes sums, gray and output states, in sobel edge mode for inner
// pixels also gradients, squares and a root search (one root bit per cycle), so it is the slower
// side, and once the queue fills it sets the sustained rate; a width write stalls input for the
// position divide and size multiply, a height write for the multiply
// reset clears counters and window, sets registers to defaults; line stores need no clearing pass
module image_3x3_convolution_filter_top #(
  parameter int unsigned MAX_WIDTH   = conv3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = conv3_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          is_flush_i,
  input  logic [7:0]                    red_in_i,
  input  logic [7:0]                    green_in_i,
  input  logic [7:0]                    blue_in_i,
  input  logic [7:0]                    alpha_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    red_out_o,
  output logic [7:0]                    green_out_o,
  output logic [7:0]                    blue_out_o,
  output logic [7:0]                    alpha_out_o,
  output logic                          end_of_frame_o,
  // register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [conv3_pkg::IDX_CW-1:0]  cfg_index_i,
  input  logic [conv3_pkg::CFG_W-1:0]   cfg_data_i
);

  // window snapshots travel from front to back through a short queue
  logic                 q_push, q_pop, q_full, q_empty;
  conv3_pkg::entry_t    q_in, q_out;
  conv3_pkg::filt_cfg_t filt_cfg;

  // front: pixel transactions, line stores, counters and register writes
  conv3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .is_flush_i  (is_flush_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .alpha_in_i  (alpha_in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in),
    .filt_cfg_o  (filt_cfg)
  );

  // decoupling queue, so either side may stall on its own
  conv3_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: kernel arithmetic and the output register
  conv3_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (!q_empty),
    .q_entry_i      (q_out),
    .q_pop_o        (q_pop),
    .filt_cfg_i     (filt_cfg),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .alpha_out_o    (alpha_out_o),
    .end_of_frame_o (end_of_frame_o)
  );

`ifndef ASSERT_OFF
  // the front only pushes when it checked for room at pixel acceptance
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full)) else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty)) else $error("queue underflow");

  // geometry writes recompute position and frame size before the next pixel
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i == conv3_pkg::REG_WIDTH
      || cfg_index_i == conv3_pkg::REG_HEIGHT)) |=> in_stall_o)
    else $error("pixel taken during geometry update");
`endif

endmodule
